[sv/smsl_pkg.sv]
// Package for the servo mixer with slew limit: widths, register codes and channel payloads.
// No dependencies. Used by smsl_if.sv and servo_mixer_slew_limit.sv.
`timescale 1ns / 1ps
`default_nettype none

package smsl_pkg;

    localparam int RULE_COUNT   = 4;
    localparam int NUM_SERVOS   = 4;
    localparam int ACTIVE_RULES = (NUM_SERVOS < RULE_COUNT) ? NUM_SERVOS : RULE_COUNT;
    localparam int RULE_IDX_W   = $clog2(RULE_COUNT);

    localparam int CMD_W      = 12;
    localparam int SRC_W      = 12;
    localparam int SLEW_W     = 13;
    localparam int RATE_W     = 8;
    localparam int SPEED_W    = 8;
    localparam int MAG_W      = 12;
    localparam int PROD_W     = 19;
    localparam int QUOT_W     = PROD_W + 1;
    localparam int REM_W      = 7;
    localparam int STEP_CNT_W = 5;
    localparam int PERCENT    = 100;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_SERVO_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_MIDDLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SERVO_RATE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_RATE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_SPEED   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MASK = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RC_MIDPOINT  = 3'd7;

    typedef struct packed {
        logic                    airplane_phase;
        logic                    passthrough;
        logic signed [SRC_W-1:0] stab_roll;
        logic signed [SRC_W-1:0] stab_pitch;
        logic signed [SRC_W-1:0] stab_yaw;
        logic signed [SRC_W-1:0] stick_roll;
        logic signed [SRC_W-1:0] stick_pitch;
        logic signed [SRC_W-1:0] stick_yaw;
        logic        [SRC_W-1:0] aux_raw;
    } t_in_item;

    typedef struct packed {
        logic [CMD_W-1:0] flaperon_cmd;
        logic [CMD_W-1:0] rudder_cmd;
        logic [CMD_W-1:0] elevator_cmd;
        logic [CMD_W-1:0] aux_cmd;
    } t_out_item;

endpackage

`default_nettype wire

[sv/smsl_if.sv]
// Valid/ready channel interfaces for input items, result items and register writes.
// Depends on smsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface smsl_in_if;
    logic                valid;
    logic                ready;
    smsl_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smsl_out_if;
    logic                valid;
    logic                ready;
    smsl_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smsl_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [smsl_pkg::CFG_IDX_W-1:0]      index;
    logic [smsl_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/servo_mixer_slew_limit.sv]
// Servo mixer with per-rule slew limit, bit-serial multiply and divide-by-100.
// Depends on smsl_pkg and the channel interfaces in smsl_if.sv.
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    t_in_item (phase, passthrough, stab/stick, aux_raw)
//  o_out     out  valid/ready    t_out_item (four 12-bit servo commands)
//  i_cfg     in   valid/ready    index (3b), data (12b); ready always high
//
// One item at a time; outside airplane phase the item skips the rule passes.
// Each rule runs two shift-add multiplies by an 8-bit rate and two 19-bit
// restoring divides by 100 on one shared serial unit.
// Input ready only while idle; the output register holds a result while the next
// item is taken. Synchronous active-low reset restores register defaults, zero slew.
`timescale 1ns / 1ps
`default_nettype none

module servo_mixer_slew_limit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    smsl_in_if.sink    i_in,
    smsl_out_if.source o_out,
    smsl_cfg_if.sink   i_cfg
);
    import smsl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SLEW = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_POST = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic [RULE_IDX_W-1:0] LAST_RULE = RULE_IDX_W'(ACTIVE_RULES - 1);
    localparam logic [STEP_CNT_W-1:0] MUL_LAST  = STEP_CNT_W'(RATE_W - 1);
    localparam logic [STEP_CNT_W-1:0] DIV_LAST  = STEP_CNT_W'(PROD_W - 1);
    localparam logic [REM_W:0]        DIVISOR   = (REM_W + 1)'(PERCENT);

    logic [2:0] r_state, n_state;

    logic [CMD_W-1:0]          r_servo_min, r_servo_max, r_servo_middle, r_rc_midpoint;
    logic signed [RATE_W-1:0]  r_servo_rate, r_mix_rate;
    logic [SPEED_W-1:0]        r_slew_speed;
    logic [RULE_COUNT-1:0]     r_reverse_mask;

    logic signed [SLEW_W-1:0]  r_slew [RULE_COUNT];
    logic [CMD_W-1:0]          r_cmd  [RULE_COUNT];
    t_in_item                  r_item;
    logic [RULE_IDX_W-1:0]     r_idx;
    logic                      r_pass;
    logic [PROD_W-1:0]         r_mcand;
    logic [RATE_W-1:0]         r_mplier;
    logic [PROD_W-1:0]         r_acc;
    logic [REM_W-1:0]          r_rem;
    logic [STEP_CNT_W-1:0]     r_cnt;
    logic                      r_neg;
    t_out_item                 r_out;
    logic                      r_out_valid;

    logic                      w_accept, w_out_load;
    logic signed [SLEW_W-1:0]  w_src, w_old, w_new;
    logic signed [SLEW_W:0]    w_old_x, w_src_x, w_up, w_dn;
    logic [SLEW_W-1:0]         w_new_abs;
    logic [RATE_W-1:0]         w_mix_mag, w_rate_mag;
    logic [REM_W:0]            w_trial;
    logic                      w_ge;
    logic signed [QUOT_W-1:0]  w_q, w_lo, w_hi, w_term, w_term_r, w_term_abs, w_c, w_c_cl;
    logic [CMD_W-1:0]          w_width;
    logic [CMD_W-2:0]          w_half;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // source select
    always_comb begin
        unique case (r_idx)
            2'd0: w_src = SLEW_W'(r_item.passthrough ? r_item.stick_roll  : r_item.stab_roll);
            2'd1: w_src = SLEW_W'(r_item.passthrough ? r_item.stick_yaw   : r_item.stab_yaw);
            2'd2: w_src = SLEW_W'(r_item.passthrough ? r_item.stick_pitch : r_item.stab_pitch);
            default: w_src = signed'({1'b0, r_item.aux_raw} - {1'b0, r_rc_midpoint});
        endcase
    end

    // slew limiter
    assign w_old   = r_slew[r_idx];
    assign w_old_x = (SLEW_W + 1)'(w_old);
    assign w_src_x = (SLEW_W + 1)'(w_src);
    assign w_up    = w_old_x + signed'({6'b0, r_slew_speed});
    assign w_dn    = w_old_x - signed'({6'b0, r_slew_speed});

    always_comb begin
        priority if (r_slew_speed == '0) begin
            w_new = w_src;
        end else if (w_old < w_src) begin
            w_new = (w_up > w_src_x) ? w_src : w_up[SLEW_W-1:0];
        end else if (w_old > w_src) begin
            w_new = (w_dn < w_src_x) ? w_src : w_dn[SLEW_W-1:0];
        end else begin
            w_new = w_old;
        end
    end

    assign w_new_abs  = w_new[SLEW_W-1] ? SLEW_W'(-w_new) : w_new;
    assign w_mix_mag  = r_mix_rate[RATE_W-1] ? RATE_W'(-r_mix_rate) : r_mix_rate;
    assign w_rate_mag = r_servo_rate[RATE_W-1] ? RATE_W'(-r_servo_rate) : r_servo_rate;

    // restoring divide step
    assign w_trial = {r_rem, r_acc[PROD_W-1]};
    assign w_ge    = (w_trial >= DIVISOR);

    // post-processing of the signed quotient
    assign w_q     = r_neg ? -signed'({1'b0, r_acc}) : signed'({1'b0, r_acc});
    assign w_width = (r_servo_max >= r_servo_min) ? (r_servo_max - r_servo_min) : '0;
    assign w_half  = w_width[CMD_W-1:1];
    assign w_lo    = -signed'(QUOT_W'(w_half));
    assign w_hi    = signed'(QUOT_W'(w_width)) - signed'(QUOT_W'(w_half));

    always_comb begin
        priority if (w_q < w_lo) begin
            w_term = w_lo;
        end else if (w_q > w_hi) begin
            w_term = w_hi;
        end else begin
            w_term = w_q;
        end
    end

    assign w_term_r   = r_reverse_mask[r_idx] ? -w_term : w_term;
    assign w_term_abs = w_term_r[QUOT_W-1] ? -w_term_r : w_term_r;
    assign w_c        = w_q + signed'(QUOT_W'(r_servo_middle));

    always_comb begin
        priority if (w_c < signed'(QUOT_W'(r_servo_min))) begin
            w_c_cl = signed'(QUOT_W'(r_servo_min));
        end else if (w_c > signed'(QUOT_W'(r_servo_max))) begin
            w_c_cl = signed'(QUOT_W'(r_servo_max));
        end else begin
            w_c_cl = w_c;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) begin
                n_state = i_in.data.airplane_phase ? S_SLEW : S_DONE;
            end
            S_SLEW: n_state = S_MUL;
            S_MUL:  if (r_cnt == MUL_LAST) begin
                n_state = S_DIV;
            end
            S_DIV:  if (r_cnt == DIV_LAST) begin
                n_state = S_POST;
            end
            S_POST: begin
                if (!r_pass) begin
                    n_state = S_MUL;
                end else if (r_idx == LAST_RULE) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SLEW;
                end
            end
            S_DONE: if (w_out_load) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control, configuration and slew state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_servo_min    <= CMD_W'(1000);
            r_servo_max    <= CMD_W'(2000);
            r_servo_middle <= CMD_W'(1500);
            r_servo_rate   <= RATE_W'(100);
            r_mix_rate     <= RATE_W'(100);
            r_slew_speed   <= '0;
            r_reverse_mask <= '0;
            r_rc_midpoint  <= CMD_W'(1500);
            for (int i = 0; i < RULE_COUNT; i++) begin
                r_slew[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_SLEW) begin
                r_slew[r_idx] <= w_new;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_SERVO_MIN:    r_servo_min    <= i_cfg.data[CMD_W-1:0];
                    REG_SERVO_MAX:    r_servo_max    <= i_cfg.data[CMD_W-1:0];
                    REG_SERVO_MIDDLE: r_servo_middle <= i_cfg.data[CMD_W-1:0];
                    REG_SERVO_RATE:   r_servo_rate   <= i_cfg.data[RATE_W-1:0];
                    REG_MIX_RATE:     r_mix_rate     <= i_cfg.data[RATE_W-1:0];
                    REG_SLEW_SPEED:   r_slew_speed   <= i_cfg.data[SPEED_W-1:0];
                    REG_REVERSE_MASK: r_reverse_mask <= i_cfg.data[RULE_COUNT-1:0];
                    REG_RC_MIDPOINT:  r_rc_midpoint  <= i_cfg.data[CMD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // serial datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_item <= i_in.data;
                    r_idx  <= '0;
                    for (int i = 0; i < RULE_COUNT; i++) begin
                        r_cmd[i] <= '0;
                    end
                end
            end
            S_SLEW: begin
                r_mcand  <= PROD_W'(w_new_abs);
                r_mplier <= w_mix_mag;
                r_neg    <= w_new[SLEW_W-1] ^ r_mix_rate[RATE_W-1];
                r_acc    <= '0;
                r_cnt    <= '0;
                r_pass   <= 1'b0;
            end
            S_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[RATE_W-1:1]};
                r_rem    <= '0;
                r_cnt    <= (r_cnt == MUL_LAST) ? '0 : r_cnt + 1'b1;
            end
            S_DIV: begin
                r_rem <= w_ge ? REM_W'(w_trial - DIVISOR) : w_trial[REM_W-1:0];
                r_acc <= {r_acc[PROD_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            S_POST: begin
                if (!r_pass) begin
                    r_mcand  <= w_term_abs[PROD_W-1:0];
                    r_mplier <= w_rate_mag;
                    r_neg    <= w_term_r[QUOT_W-1] ^ r_servo_rate[RATE_W-1];
                    r_acc    <= '0;
                    r_cnt    <= '0;
                    r_pass   <= 1'b1;
                end else begin
                    r_cmd[r_idx] <= w_c_cl[CMD_W-1:0];
                    if (r_idx != LAST_RULE) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    r_out.flaperon_cmd <= r_cmd[0];
                    r_out.rudder_cmd   <= r_cmd[1];
                    r_out.elevator_cmd <= r_cmd[2];
                    r_out.aux_cmd      <= r_cmd[3];
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[bench/tb_servo_mixer_slew_limit.sv]
// Testbench for servo_mixer_slew_limit: a directed table, then randomized control cycles
// under several register settings and idle patterns, checked against a local mixer model.
// Depends on smsl_pkg, the channel interfaces in smsl_if.sv and the servo_mixer_slew_limit RTL.
`timescale 1ns / 1ps

module tb_servo_mixer_slew_limit;
    import smsl_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_PAUSE    = 8;
    localparam int TAIL_CYCLES    = 300;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_ITEMS    = 55;
    localparam int SEND_IDLE_PCT [4] = '{0, 64, 0, 25};
    localparam int STALL_PCT     [4] = '{0, 0, 64, 25};

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        t_in_item              item;
        bit                    has_fixed;
        t_out_item             fixed;
    } t_step;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    smsl_in_if  in_bus ();
    smsl_out_if out_bus ();
    smsl_cfg_if cfg_bus ();

    servo_mixer_slew_limit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // mixer model state and register copy
    int servo_min    = 1000;
    int servo_max    = 2000;
    int servo_middle = 1500;
    int servo_rate   = 100;
    int mix_rate     = 100;
    int slew_speed   = 0;
    int reverse_mask = 0;
    int rc_midpoint  = 1500;
    int slew_state [RULE_COUNT] = '{default: 0};

    t_out_item pending_cmds [$];
    t_step     steps [$];
    int        errors        = 0;
    int        idle_cycles   = 0;
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    bit        fixed_cmd_en  = 1'b0;
    t_out_item fixed_cmd     = '0;

    always #5 clk = ~clk;

    function automatic int clamp_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_SERVO_MIN:    servo_min    = int'(d);
            REG_SERVO_MAX:    servo_max    = int'(d);
            REG_SERVO_MIDDLE: servo_middle = int'(d);
            REG_SERVO_RATE:   servo_rate   = int'($signed(d[RATE_W-1:0]));
            REG_MIX_RATE:     mix_rate     = int'($signed(d[RATE_W-1:0]));
            REG_SLEW_SPEED:   slew_speed   = int'(d[SPEED_W-1:0]);
            REG_REVERSE_MASK: reverse_mask = int'(d[3:0]);
            REG_RC_MIDPOINT:  rc_midpoint  = int'(d);
            default: ;
        endcase
    endfunction

    // one control cycle: slew, mix, clamp to span, reverse, scale, center, clamp
    function automatic t_out_item mix_servo_cmds(input t_in_item it);
        int               src [RULE_COUNT];
        int               term [RULE_COUNT];
        logic [CMD_W-1:0] cmd [RULE_COUNT];
        int               width, lo, hi, o, c, i;
        t_out_item        r;
        r = '0;
        if (!it.airplane_phase) begin
            return r;
        end
        src[0] = it.passthrough ? int'(it.stick_roll)  : int'(it.stab_roll);
        src[1] = it.passthrough ? int'(it.stick_yaw)   : int'(it.stab_yaw);
        src[2] = it.passthrough ? int'(it.stick_pitch) : int'(it.stab_pitch);
        src[3] = int'(it.aux_raw) - rc_midpoint;
        width = (servo_max >= servo_min) ? servo_max - servo_min : 0;
        lo = -(width / 2);
        hi = width - width / 2;
        for (i = 0; i < RULE_COUNT; i++) begin
            term[i] = 0;
            cmd[i]  = '0;
        end
        for (i = 0; i < ACTIVE_RULES; i++) begin
            o = slew_state[i];
            if (slew_speed == 0) begin
                o = src[i];
            end else if (o < src[i]) begin
                o = o + slew_speed;
                if (o > src[i]) o = src[i];
            end else if (o > src[i]) begin
                o = o - slew_speed;
                if (o < src[i]) o = src[i];
            end
            slew_state[i] = o;
            term[i] = clamp_int((o * mix_rate) / PERCENT, lo, hi);
            if (reverse_mask[i]) term[i] = -term[i];
        end
        for (i = 0; i < ACTIVE_RULES; i++) begin
            c = (servo_rate * term[i]) / PERCENT + servo_middle;
            c = clamp_int(c, servo_min, servo_max);
            cmd[i] = c[CMD_W-1:0];
        end
        r = '{cmd[0], cmd[1], cmd[2], cmd[3]};
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [CMD_W-1:0] got,
                               input logic [CMD_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    always @(posedge clk) begin : monitor
        t_out_item want;
        bit        moved;
        if (rst_n) begin
            moved = 1'b0;
            if (in_bus.valid && in_bus.ready) begin
                want = mix_servo_cmds(in_bus.data);
                if (fixed_cmd_en) want = fixed_cmd;
                pending_cmds.push_back(want);
                moved = 1'b1;
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                apply_reg(cfg_bus.index, cfg_bus.data);
                moved = 1'b1;
            end
            if (out_bus.valid && out_bus.ready) begin
                moved = 1'b1;
                if (pending_cmds.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing expected", out_bus.data));
                end else begin
                    want = pending_cmds.pop_front();
                    check_field("flaperon_cmd", out_bus.data.flaperon_cmd, want.flaperon_cmd);
                    check_field("rudder_cmd",   out_bus.data.rudder_cmd,   want.rudder_cmd);
                    check_field("elevator_cmd", out_bus.data.elevator_cmd, want.elevator_cmd);
                    check_field("aux_cmd",      out_bus.data.aux_cmd,      want.aux_cmd);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("** servo_mixer_slew_limit: FAILED **");
        $finish;
    end

    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_bus.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic t_in_item make_item(input bit ph, input bit pass, input int sr,
                                           input int sp, input int sy, input int kr,
                                           input int kp, input int ky, input int aux);
        t_in_item it;
        it.airplane_phase = ph;
        it.passthrough    = pass;
        it.stab_roll      = sr[SRC_W-1:0];
        it.stab_pitch     = sp[SRC_W-1:0];
        it.stab_yaw       = sy[SRC_W-1:0];
        it.stick_roll     = kr[SRC_W-1:0];
        it.stick_pitch    = kp[SRC_W-1:0];
        it.stick_yaw      = ky[SRC_W-1:0];
        it.aux_raw        = aux[SRC_W-1:0];
        return it;
    endfunction

    function automatic void add_item(input t_in_item it, input bit has_fixed,
                                     input t_out_item fx);
        t_step s;
        s = '{default: '0};
        s.item      = it;
        s.has_fixed = has_fixed;
        s.fixed     = fx;
        steps.push_back(s);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        t_step s;
        s = '{default: '0};
        s.is_write = 1'b1;
        s.reg_idx  = idx;
        s.reg_data = d;
        steps.push_back(s);
    endfunction

    function automatic logic [SRC_W-1:0] rand_src();
        case ($urandom_range(9))
            0:       return 12'h800;
            1:       return 12'h7FF;
            2:       return 12'h000;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.airplane_phase = ($urandom_range(99) < 85);
        it.passthrough    = 1'($urandom_range(1));
        it.stab_roll      = rand_src();
        it.stab_pitch     = rand_src();
        it.stab_yaw       = rand_src();
        it.stick_roll     = rand_src();
        it.stick_pitch    = rand_src();
        it.stick_yaw      = rand_src();
        case ($urandom_range(9))
            0:       it.aux_raw = 12'd0;
            1:       it.aux_raw = 12'd4095;
            2:       it.aux_raw = rc_midpoint[SRC_W-1:0];
            default: it.aux_raw = 12'($urandom);
        endcase
        return it;
    endfunction

    task automatic drive_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid = 1'b0;
            @(negedge clk);
        end
        in_bus.valid = 1'b1;
        in_bus.data  = it;
        do @(posedge clk); while (!in_bus.ready);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        in_bus.valid = 1'b0;
        while (pending_cmds.size() != 0) @(negedge clk);
        repeat (DRAIN_PAUSE) @(negedge clk);
    endtask

    // leaves valid high so back-to-back writes need no gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = d;
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
    endtask

    task automatic program_setting(input int p);
        logic [CFG_DATA_W-1:0] v_min, v_max, v_mid, v_rate, v_mix, v_slew, v_rev, v_rc, t;
        int                    pct;
        case (p)
            0: begin
                v_min = 12'd1000; v_max = 12'd2000; v_mid = 12'd1500; v_rate = 12'd100;
                v_mix = 12'd100;  v_slew = 12'd0;   v_rev = 12'h0;    v_rc = 12'd1500;
            end
            1: begin
                v_min = 12'd0;    v_max = 12'd4095; v_mid = 12'd2048; v_rate = 12'h07F;
                v_mix = 12'h080;  v_slew = 12'd1;   v_rev = 12'hF;    v_rc = 12'd0;
            end
            2: begin
                v_min = 12'd4095; v_max = 12'd0;    v_mid = 12'd0;    v_rate = 12'h080;
                v_mix = 12'h07F;  v_slew = 12'd255; v_rev = 12'h5;    v_rc = 12'd4095;
            end
            3: begin
                v_min = 12'd0;    v_max = 12'd4095; v_mid = 12'd4095; v_rate = 12'h09C;
                v_mix = 12'd125;  v_slew = 12'd0;   v_rev = 12'hA;    v_rc = 12'd2048;
            end
            default: begin
                v_min = 12'($urandom);
                v_max = 12'($urandom);
                if ($urandom_range(3) != 0 && v_min > v_max) begin
                    t = v_min; v_min = v_max; v_max = t;
                end
                v_mid = 12'($urandom);
                pct = $urandom_range(200) - 100;
                v_rate = $urandom_range(3) == 0 ? 12'($urandom) : pct[CFG_DATA_W-1:0];
                pct = $urandom_range(250) - 125;
                v_mix = $urandom_range(3) == 0 ? 12'($urandom) : pct[CFG_DATA_W-1:0];
                case ($urandom_range(2))
                    0:       v_slew = 12'd0;
                    1:       v_slew = 12'($urandom_range(16, 1));
                    default: v_slew = 12'($urandom);
                endcase
                v_rev = 12'($urandom);
                v_rc  = 12'($urandom);
            end
        endcase
        wait_drain();
        write_reg(REG_SERVO_MIN, v_min);
        write_reg(REG_SERVO_MAX, v_max);
        write_reg(REG_SERVO_MIDDLE, v_mid);
        write_reg(REG_SERVO_RATE, v_rate);
        write_reg(REG_MIX_RATE, v_mix);
        write_reg(REG_SLEW_SPEED, v_slew);
        write_reg(REG_REVERSE_MASK, v_rev);
        write_reg(REG_RC_MIDPOINT, v_rc);
        cfg_bus.valid = 1'b0;
    endtask

    initial begin : stimulus
        t_in_item last_item;
        bit       writing;
        int       p, n;

        in_bus.valid  = 1'b0;
        in_bus.data   = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data  = '0;
        writing       = 1'b0;

        // reset defaults, slew off: commands readable directly
        add_item(make_item(0, 1, 2047, -2048, 2047, -2048, 2047, -2048, 4095), 1, '0);
        add_item(make_item(1, 0, 0, 0, 0, 0, 0, 0, 1500), 1,
                 '{12'd1500, 12'd1500, 12'd1500, 12'd1500});
        add_item(make_item(1, 0, 2047, -2048, 2047, 0, 0, 0, 4095), 1,
                 '{12'd2000, 12'd2000, 12'd1000, 12'd2000});
        add_item(make_item(1, 0, -2048, 2047, -2048, 0, 0, 0, 0), 1,
                 '{12'd1000, 12'd1000, 12'd2000, 12'd1000});
        add_item(make_item(1, 1, -2048, 2047, 2047, 2047, -2048, -2048, 1500), 1,
                 '{12'd2000, 12'd1000, 12'd1000, 12'd1500});
        add_item(make_item(0, 0, -1, -1, -1, -1, -1, -1, 4095), 1, '0);
        // slew limiting, and held state outside airplane phase
        add_write(REG_SLEW_SPEED, 12'd100);
        add_item(make_item(1, 0, 0, 0, 0, 0, 0, 0, 1500), 0, '0);
        add_item(make_item(1, 0, 0, 0, 0, 0, 0, 0, 1500), 0, '0);
        add_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 1500), 0, '0);
        add_item(make_item(1, 0, 0, 0, 0, 0, 0, 0, 1500), 0, '0);
        add_write(REG_REVERSE_MASK, 12'hF);
        add_item(make_item(1, 1, 0, 0, 0, 1000, -1000, 500, 3000), 0, '0);
        // min above max
        add_write(REG_SERVO_MIN, 12'd3000);
        add_write(REG_SERVO_MAX, 12'd1000);
        add_item(make_item(1, 0, 700, -700, 300, 0, 0, 0, 100), 0, '0);
        add_item(make_item(1, 1, 0, 0, 0, -900, 900, -300, 4000), 0, '0);
        // out-of-range rates, full span
        add_write(REG_SLEW_SPEED, 12'd0);
        add_write(REG_SERVO_RATE, 12'h080);
        add_write(REG_MIX_RATE, 12'h07F);
        add_write(REG_SERVO_MIN, 12'd0);
        add_write(REG_SERVO_MAX, 12'd4095);
        add_write(REG_SERVO_MIDDLE, 12'd4095);
        add_item(make_item(1, 0, 2047, -2048, -2048, 0, 0, 0, 4095), 0, '0);
        add_item(make_item(1, 0, -2048, 2047, 2047, 0, 0, 0, 0), 0, '0);
        add_write(REG_SERVO_MIDDLE, 12'd0);
        add_write(REG_SERVO_RATE, 12'h07F);
        add_write(REG_MIX_RATE, 12'h080);
        add_write(REG_RC_MIDPOINT, 12'd0);
        add_item(make_item(1, 0, 2047, -2048, -2048, 0, 0, 0, 4095), 0, '0);
        add_item(make_item(1, 0, -2048, 2047, 2047, 0, 0, 0, 0), 0, '0);
        add_write(REG_RC_MIDPOINT, 12'd4095);
        add_write(REG_SLEW_SPEED, 12'd255);
        add_item(make_item(1, 1, 0, 0, 0, 2047, 2047, 2047, 0), 0, '0);
        add_item(make_item(1, 1, 0, 0, 0, -2048, -2048, -2048, 4095), 0, '0);
        add_write(REG_SLEW_SPEED, 12'd1);
        add_item(make_item(1, 0, 2047, 2047, 2047, 0, 0, 0, 4095), 0, '0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (steps[k]) begin
            if (steps[k].is_write) begin
                if (!writing) wait_drain();
                writing = 1'b1;
                write_reg(steps[k].reg_idx, steps[k].reg_data);
            end else begin
                cfg_bus.valid = 1'b0;
                writing       = 1'b0;
                fixed_cmd_en  = steps[k].has_fixed;
                fixed_cmd     = steps[k].fixed;
                drive_item(steps[k].item);
            end
        end
        fixed_cmd_en = 1'b0;

        for (p = 0; p < PHASE_COUNT; p++) begin
            program_setting(p);
            send_idle_pct = SEND_IDLE_PCT[p % 4];
            stall_pct     = STALL_PCT[p % 4];
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // repeated items let the slew limiter settle onto a held source
                if (n == 0 || $urandom_range(99) >= 30) last_item = rand_item();
                drive_item(last_item);
            end
        end

        in_bus.valid = 1'b0;
        while (pending_cmds.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0) begin
            $display("** servo_mixer_slew_limit: PASSED **");
        end else begin
            $display("** servo_mixer_slew_limit: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
sv/smsl_pkg.sv
sv/smsl_if.sv
sv/servo_mixer_slew_limit.sv
bench/tb_servo_mixer_slew_limit.sv
